[sv/rdm_pkg.sv]
// Shared widths and register indexes for the reciprocal divide/modulus block.
package rdm_pkg;

	localparam int unsigned DataW  = 64;
	localparam int unsigned RecipW = 128;
	localparam int unsigned AccW   = 192;
	localparam int unsigned LimbW  = 32;
	localparam int unsigned IdxW   = 2;

	localparam logic [IdxW-1:0] REG_DIVISOR   = 2'd0;
	localparam logic [IdxW-1:0] REG_WIDE_MODE = 2'd1;

	localparam logic [DataW-1:0] DIVISOR_RESET = 64'd2;

endpackage

[sv/reciprocal_divide_modulus.sv]
// Reciprocal divider: q = floor(M*a / 2^k), r = high part of (M*a mod 2^k) * d.
// The 32x32 multiplier forms 8 partial products per multiply in 64-bit mode and 2 in 32-bit
// mode, two multiplies per item; a bad divisor is reported without multiplying.
// The first good-divisor item after reset or a divisor or mode write also runs the restoring
// reciprocal division, one bit per cycle.
// busy is high for the whole item except a bad-divisor one; a new item is taken in the cycle done is shown.
// arst_n clears control state; divisor resets to 2, wide_mode to 1, no reciprocal held.
module reciprocal_divide_modulus (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rdm_pkg::IdxW-1:0]          cfg_index,
	input  logic [rdm_pkg::DataW-1:0]         cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [rdm_pkg::DataW-1:0]         dividend,
	output logic                              done,
	output logic [rdm_pkg::DataW-1:0]         quotient,
	output logic [rdm_pkg::DataW-1:0]         remainder,
	output logic                              bad_divisor
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_RINC  = 3'd2;
	localparam logic [2:0] ST_MUL1  = 3'd3;
	localparam logic [2:0] ST_WAIT1 = 3'd4;
	localparam logic [2:0] ST_MUL2  = 3'd5;
	localparam logic [2:0] ST_WAIT2 = 3'd6;

	logic [2:0]                        state_q;
	logic [rdm_pkg::DataW-1:0]         divisor_q;
	logic                              wide_q;
	logic                              ready_q;
	logic [6:0]                        cnt_q;
	logic [1:0]                        i_q;
	logic                              j_q;
	logic                              vld_s1;
	logic                              done_q;

	logic [rdm_pkg::DataW-1:0]         d_q;
	logic [rdm_pkg::DataW-1:0]         rem_q;
	logic [rdm_pkg::RecipW-1:0]        rec_q;
	logic [rdm_pkg::RecipW-1:0]        opa_q;
	logic [rdm_pkg::DataW-1:0]         opb_q;
	logic [rdm_pkg::AccW-1:0]          acc_q;
	logic [rdm_pkg::DataW-1:0]         prod_s1;
	logic [2:0]                        col_s1;
	logic [rdm_pkg::DataW-1:0]         quot_q;
	logic [rdm_pkg::DataW-1:0]         quotient_q;
	logic [rdm_pkg::DataW-1:0]         remainder_q;
	logic                              bad_q;

	logic                              accept;
	logic [rdm_pkg::DataW-1:0]         d_eff;
	logic                              d_bad;
	logic [rdm_pkg::DataW:0]           div_sh;
	logic                              div_ge;
	logic [6:0]                        div_last;
	logic [rdm_pkg::RecipW-1:0]        rec_inc;
	logic [1:0]                        last_i;
	logic                              last_j;
	logic                              mul_issue;
	logic [rdm_pkg::LimbW-1:0]         limb_a;
	logic [rdm_pkg::LimbW-1:0]         limb_b;
	logic [rdm_pkg::DataW-1:0]         prod;
	logic [7:0]                        sh_amt;
	logic [rdm_pkg::AccW-1:0]          acc_next;

	assign accept = start && (state_q == ST_IDLE);
	assign d_eff  = wide_q ? divisor_q : {32'd0, divisor_q[31:0]};
	assign d_bad  = (d_eff[rdm_pkg::DataW-1:1] == '0);

	// restoring division of an all-ones dividend: shift in a one each step
	assign div_sh   = {rem_q, 1'b1};
	assign div_ge   = (div_sh >= {1'b0, d_q});
	assign div_last = wide_q ? 7'd127 : 7'd63;
	assign rec_inc  = rec_q + rdm_pkg::RecipW'(1);

	// limb counts: 4x2 in 64-bit mode, 2x1 in 32-bit mode
	assign last_i    = wide_q ? 2'd3 : 2'd1;
	assign last_j    = wide_q;
	assign mul_issue = (state_q == ST_MUL1) || (state_q == ST_MUL2);

	assign limb_a   = opa_q[{i_q, 5'd0} +: rdm_pkg::LimbW];
	assign limb_b   = opb_q[{j_q, 5'd0} +: rdm_pkg::LimbW];
	assign prod     = {32'd0, limb_a} * {32'd0, limb_b};
	assign sh_amt   = {col_s1, 5'd0};
	assign acc_next = vld_s1 ? acc_q + ({128'd0, prod_s1} << sh_amt) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			divisor_q <= rdm_pkg::DIVISOR_RESET;
			wide_q    <= 1'b1;
			ready_q   <= 1'b0;
			cnt_q     <= '0;
			i_q       <= '0;
			j_q       <= 1'b0;
			vld_s1    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= mul_issue;
			if (cfg_we) begin
				case (cfg_index)
					rdm_pkg::REG_DIVISOR: begin
						divisor_q <= cfg_data;
						ready_q   <= 1'b0;
					end
					rdm_pkg::REG_WIDE_MODE: begin
						wide_q  <= cfg_data[0];
						ready_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						i_q   <= '0;
						j_q   <= 1'b0;
						cnt_q <= '0;
						if (d_bad) begin
							done_q <= 1'b1;
						end else if (!ready_q) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_MUL1;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == div_last) begin
						state_q <= ST_RINC;
					end
				end
				ST_RINC: begin
					ready_q <= 1'b1;
					state_q <= ST_MUL1;
				end
				ST_MUL1, ST_MUL2: begin
					if (i_q == last_i) begin
						i_q <= '0;
						j_q <= ~j_q;
						if (j_q == last_j) begin
							j_q     <= 1'b0;
							state_q <= (state_q == ST_MUL1) ? ST_WAIT1 : ST_WAIT2;
						end
					end else begin
						i_q <= i_q + 2'd1;
					end
				end
				ST_WAIT1: begin
					state_q <= ST_MUL2;
				end
				ST_WAIT2: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		col_s1  <= {1'b0, i_q} + {2'd0, j_q};
		// sum restarts for each item and again for the second multiply
		acc_q   <= (accept || (state_q == ST_WAIT1)) ? '0 : acc_next;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					d_q    <= d_eff;
					rem_q  <= '0;
					opa_q  <= rec_q;
					opb_q  <= wide_q ? dividend : {32'd0, dividend[31:0]};
					bad_q  <= d_bad;
					quotient_q  <= '0;
					remainder_q <= '0;
					if (!ready_q) begin
						rec_q <= '0;
					end
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? div_sh[rdm_pkg::DataW-1:0] - d_q : div_sh[rdm_pkg::DataW-1:0];
				rec_q <= {rec_q[rdm_pkg::RecipW-2:0], div_ge};
			end
			ST_RINC: begin
				rec_q <= rec_inc;
				opa_q <= rec_inc;
			end
			ST_WAIT1: begin
				// product M*a complete: take the quotient, feed the low part back against d
				quot_q <= wide_q ? acc_next[191:128] : acc_next[127:64];
				opa_q  <= wide_q ? acc_next[127:0] : {64'd0, acc_next[63:0]};
				opb_q  <= d_q;
			end
			ST_WAIT2: begin
				quotient_q  <= quot_q;
				remainder_q <= wide_q ? acc_next[191:128] : acc_next[127:64];
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign quotient    = quotient_q;
	assign remainder   = remainder_q;
	assign bad_divisor = bad_q;

endmodule

[sv/rdm_checker.sv]
// Port-level checks for the reciprocal divider, bound to the top level.
module rdm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [rdm_pkg::DataW-1:0] quotient,
	input logic [rdm_pkg::DataW-1:0] remainder,
	input logic                      bad_divisor
);

	// an accepted beat either starts work or reports a bad divisor at once
	a_accept_reacts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted beat produced neither busy nor done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done shown while busy");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_divisor) |-> (quotient == '0 && remainder == '0))
		else $error("bad divisor result not zero");

endmodule

bind reciprocal_divide_modulus rdm_checker u_rdm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.quotient    (quotient),
	.remainder   (remainder),
	.bad_divisor (bad_divisor)
);

[test/reciprocal_divide_modulus_tb.sv]
// Testbench for reciprocal_divide_modulus: directed table plus random phases, checked by typed results or a predictor.
module reciprocal_divide_modulus_tb;

	localparam logic [rdm_pkg::IdxW-1:0]  REG_SPARE2  = 2'd2;
	localparam logic [rdm_pkg::IdxW-1:0]  REG_SPARE3  = 2'd3;
	localparam logic [rdm_pkg::DataW-1:0] ALL_ONES    = '1;
	localparam int                        DRAIN_LIMIT = 1000;
	localparam int                        PHASES      = 22;
	localparam int                        PHASE_BEATS = 50;

	typedef struct packed {
		logic [rdm_pkg::DataW-1:0] quo;
		logic [rdm_pkg::DataW-1:0] rem;
		logic                      bad;
	} divmod_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [rdm_pkg::IdxW-1:0]  idx;
		logic [rdm_pkg::DataW-1:0] value;
		logic                      typed;
		divmod_t                   result;
	} stim_row_t;

	// Items carry the dividend in value; register rows carry the write data.
	localparam stim_row_t DIRECTED_ROWS [36] = '{
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'h0, 1'b1, '{64'h0, 64'h0, 1'b0}},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, ALL_ONES, 1'b1,
			'{64'h7FFF_FFFF_FFFF_FFFF, 64'h1, 1'b0}},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'h1, 1'b1, '{64'h0, 64'h1, 1'b0}},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'h8000_0000_0000_0000, 1'b1,
			'{64'h4000_0000_0000_0000, 64'h0, 1'b0}},
		'{ROW_CFG, rdm_pkg::REG_DIVISOR, 64'h0, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'd123, 1'b1, '{64'h0, 64'h0, 1'b1}},
		'{ROW_CFG, rdm_pkg::REG_DIVISOR, 64'h1, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, ALL_ONES, 1'b1, '{64'h0, 64'h0, 1'b1}},
		'{ROW_CFG, rdm_pkg::REG_DIVISOR, ALL_ONES, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, ALL_ONES, 1'b1, '{64'h1, 64'h0, 1'b0}},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, ALL_ONES - 64'd1, 1'b1,
			'{64'h0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0}},
		'{ROW_CFG, rdm_pkg::REG_DIVISOR, 64'h8000_0000_0000_0001, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, ALL_ONES, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'hDEAD_BEEF_0123_4567, 1'b0, '0},
		// narrow mode selected through bit 0 only
		'{ROW_CFG, rdm_pkg::REG_WIDE_MODE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
		'{ROW_CFG, rdm_pkg::REG_DIVISOR, 64'h0000_0001_0000_0000, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'd5, 1'b1, '{64'h0, 64'h0, 1'b1}},
		'{ROW_CFG, rdm_pkg::REG_DIVISOR, 64'hFFFF_FFFF_0000_0001, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, ALL_ONES, 1'b1, '{64'h0, 64'h0, 1'b1}},
		'{ROW_CFG, rdm_pkg::REG_DIVISOR, ALL_ONES, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, ALL_ONES, 1'b1, '{64'h1, 64'h0, 1'b0}},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'h1234_5678_FFFF_FFFE, 1'b1,
			'{64'h0, 64'hFFFF_FFFE, 1'b0}},
		'{ROW_CFG, rdm_pkg::REG_DIVISOR, 64'd3, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, ALL_ONES, 1'b1, '{64'h5555_5555, 64'h0, 1'b0}},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'hFFFF_FFFF_0000_0007, 1'b1,
			'{64'h2, 64'h1, 1'b0}},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'h0, 1'b1, '{64'h0, 64'h0, 1'b0}},
		// writes to unmapped indexes must leave the setting alone
		'{ROW_CFG, REG_SPARE2, 64'h0, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'd10, 1'b1, '{64'h3, 64'h1, 1'b0}},
		'{ROW_CFG, REG_SPARE3, ALL_ONES, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'd11, 1'b1, '{64'h3, 64'h2, 1'b0}},
		'{ROW_CFG, rdm_pkg::REG_DIVISOR, 64'd7, 1'b0, '0},
		'{ROW_CFG, rdm_pkg::REG_WIDE_MODE, 64'h1, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, 64'd100, 1'b1, '{64'd14, 64'd2, 1'b0}},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, ALL_ONES, 1'b0, '0},
		'{ROW_CFG, rdm_pkg::REG_DIVISOR, 64'h8000_0000, 1'b0, '0},
		'{ROW_ITEM, rdm_pkg::REG_DIVISOR, ALL_ONES, 1'b1,
			'{64'h1_FFFF_FFFF, 64'h7FFF_FFFF, 1'b0}}
	};

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [rdm_pkg::IdxW-1:0]  cfg_index;
	logic [rdm_pkg::DataW-1:0] cfg_data;
	logic                      start;
	logic                      busy;
	logic [rdm_pkg::DataW-1:0] dividend;
	logic                      done;
	logic [rdm_pkg::DataW-1:0] quotient;
	logic [rdm_pkg::DataW-1:0] remainder;
	logic                      bad_divisor;

	// predictor copy of the block's settings and held reciprocal
	logic [rdm_pkg::DataW-1:0]  held_divisor;
	logic                       held_wide;
	logic [rdm_pkg::RecipW-1:0] recip;
	logic                       recip_held;

	divmod_t pending_divmod[$];
	int      mismatch_count;

	reciprocal_divide_modulus DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.dividend   (dividend),
		.done       (done),
		.quotient   (quotient),
		.remainder  (remainder),
		.bad_divisor(bad_divisor)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [rdm_pkg::DataW-1:0] got,
			input logic [rdm_pkg::DataW-1:0] want);
		mismatch_count++;
		$display("MISMATCH %s: got %h expected %h (t=%0t)", what, got, want, $realtime);
	endtask

	function automatic divmod_t predict_divmod(input logic [rdm_pkg::DataW-1:0] a);
		logic [rdm_pkg::DataW-1:0]  d;
		logic [rdm_pkg::RecipW-1:0] ones128;
		logic [rdm_pkg::AccW-1:0]   prod;
		logic [rdm_pkg::AccW-1:0]   rprod;
		logic [127:0]               nprod;
		logic [127:0]               nrprod;
		divmod_t                    res;
		ones128 = '1;
		res = '0;
		d = held_wide ? held_divisor : {32'h0, held_divisor[31:0]};
		if (d < 64'd2) begin
			res.bad = 1'b1;
			return res;
		end
		if (!recip_held) begin
			if (held_wide)
				recip = ones128 / {64'h0, d} + 128'd1;
			else
				recip = {64'h0, ALL_ONES / d + 64'd1};
			recip_held = 1'b1;
		end
		if (held_wide) begin
			prod = {64'h0, recip} * {128'h0, a};
			res.quo = prod[191:128];
			rprod = {64'h0, prod[127:0]} * {128'h0, d};
			res.rem = rprod[191:128];
		end else begin
			nprod = {64'h0, recip[63:0]} * {96'h0, a[31:0]};
			res.quo = nprod[127:64];
			nrprod = {64'h0, nprod[63:0]} * {64'h0, d};
			res.rem = nrprod[127:64];
		end
		return res;
	endfunction

	task automatic send_dividend(input logic [rdm_pkg::DataW-1:0] a, input logic typed,
			input divmod_t typed_result);
		divmod_t want;
		@(negedge clk);
		start    <= 1'b1;
		dividend <= a;
		do @(posedge clk); while (busy);
		want = predict_divmod(a);
		if (typed)
			want = typed_result;
		pending_divmod.push_back(want);
	endtask

	// drop start and hold off until every pending result has come back or the drain limit is reached
	task automatic wait_results_drained();
		int waited;
		waited = 0;
		@(negedge clk);
		start <= 1'b0;
		while (pending_divmod.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_divmod.size() != 0) begin
			report_mismatch("results never arrived", 64'd0, 64'(pending_divmod.size()));
			pending_divmod.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rdm_pkg::IdxW-1:0] idx,
			input logic [rdm_pkg::DataW-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we   <= 1'b0;
		cfg_data <= {$urandom, $urandom};
		case (idx)
			rdm_pkg::REG_DIVISOR: begin
				held_divisor = v;
				recip_held   = 1'b0;
			end
			rdm_pkg::REG_WIDE_MODE: begin
				held_wide  = v[0];
				recip_held = 1'b0;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : check_results
		divmod_t want;
		if (arst_n && done) begin
			if (pending_divmod.size() == 0) begin
				report_mismatch("unexpected result beat", quotient, 64'd0);
			end else begin
				want = pending_divmod.pop_front();
				if (quotient !== want.quo)
					report_mismatch("quotient", quotient, want.quo);
				if (remainder !== want.rem)
					report_mismatch("remainder", remainder, want.rem);
				if (bad_divisor !== want.bad)
					report_mismatch("bad_divisor", 64'(bad_divisor), 64'(want.bad));
			end
		end
	end

	initial begin : stimulus
		logic [rdm_pkg::DataW-1:0] dv;
		logic [rdm_pkg::DataW-1:0] eff;
		logic [rdm_pkg::DataW-1:0] a;
		logic [rdm_pkg::DataW-1:0] mode_word;
		bit                        idle_on;
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = rdm_pkg::REG_DIVISOR;
		cfg_data       = '0;
		start          = 1'b0;
		dividend       = '0;
		mismatch_count = 0;
		held_divisor   = rdm_pkg::DIVISOR_RESET;
		held_wide      = 1'b1;
		recip          = '0;
		recip_held     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
				wait_results_drained();
				write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].value);
			end else begin
				send_dividend(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
					DIRECTED_ROWS[i].result);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 7))
				0: dv = 64'($urandom_range(2, 16));
				1: dv = 64'h1 << $urandom_range(1, 63);
				2: dv = {$urandom, $urandom};
				3: dv = {32'h0, 32'($urandom)};
				4: dv = ALL_ONES - 64'($urandom_range(0, 15));
				5: dv = {32'($urandom), 31'h0, 1'($urandom_range(0, 1))};
				6: dv = {32'($urandom), 32'($urandom_range(2, 9))};
				default: dv = $urandom_range(0, 1) ? ALL_ONES : 64'd2;
			endcase
			mode_word = {$urandom, $urandom};
			wait_results_drained();
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3, {$urandom, $urandom});
			case ($urandom_range(0, 2))
				0: write_reg(rdm_pkg::REG_DIVISOR, dv);
				1: begin
					write_reg(rdm_pkg::REG_WIDE_MODE, mode_word);
					write_reg(rdm_pkg::REG_DIVISOR, dv);
				end
				default: begin
					write_reg(rdm_pkg::REG_DIVISOR, dv);
					write_reg(rdm_pkg::REG_WIDE_MODE, mode_word);
				end
			endcase
			eff = held_wide ? held_divisor : {32'h0, held_divisor[31:0]};
			// a long stretch of back-to-back beats in the middle of the run
			idle_on = !(ph >= 8 && ph <= 10);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				case ($urandom_range(0, 5))
					0, 1: a = {$urandom, $urandom};
					2: a = {$urandom, 24'h0, 8'($urandom_range(0, 255))};
					3: a = eff * 64'($urandom) + 64'($urandom_range(0, 2)) - 64'd1;
					4: a = ($urandom_range(0, 1) ? ALL_ONES : 64'h0) ^
						(64'h1 << $urandom_range(0, 63));
					default: a = ALL_ONES - 64'($urandom_range(0, 1000));
				endcase
				if ((ph == 3 && n == 25) || $urandom_range(0, 199) == 0)
					wait_results_drained();
				if (idle_on && $urandom_range(0, 99) < 11) begin
					@(negedge clk);
					start    <= 1'b0;
					dividend <= {$urandom, $urandom};
					repeat ($urandom_range(0, 20)) @(negedge clk);
				end
				send_dividend(a, 1'b0, '0);
			end
		end

		wait_results_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
sv/rdm_pkg.sv
sv/reciprocal_divide_modulus.sv
sv/rdm_checker.sv
test/reciprocal_divide_modulus_tb.sv
